// ===== hw/rtl/pcr_pkg.sv =====
package pcr_pkg;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [7:0]  range_low;
        logic [7:0]  range_high;
        logic [15:0] cycle_rate;
        logic [15:0] cycle_mode;
        logic [7:0]  entry_pos;
    } t_in_word;

    typedef struct packed {
        logic [7:0] dest_index;
        logic [7:0] source_index;
        logic       time_saturated;
    } t_out_word;

    // sideband that rides along the pipeline with each word
    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] j;
        logic [8:0] size;
        logic       rev;
        logic       pp;
        logic       sine;
        logic       half;
        logic       sat;
        logic [7:0] tm_lo;
        logic [7:0] k;
    } t_side;

    localparam logic [15:0] MODE_REVERSE   = 16'd2;
    localparam logic [15:0] MODE_PINGPONG  = 16'd3;
    localparam logic [15:0] MODE_HALF_SINE = 16'd4;
    localparam logic [15:0] MODE_FULL_SINE = 16'd5;

    // rate*256*ms/280000 == 4*(rate*ms)/4375, taken as (P * TIME_RECIP) >> 53,
    // exact for every P below SAT_LIMIT
    localparam logic [42:0] TIME_RECIP = 43'd8235153604335;
    // rate*ms at or above this saturates the 31-bit time
    localparam logic [47:0] SAT_LIMIT  = 48'd2348810240000;
    localparam logic [30:0] TM_MAX     = 31'h7FFF_FFFF;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sin(ang) for a first-quadrant Q30 angle, returned as sin+1 in Q1.15
    // (negated half turn when neg is set)
    function automatic logic [15:0] sine_val(input logic [63:0] ang, input logic neg);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] s;
        x2   = (ang * ang) >> 30;
        term = ang;
        sum  = ang;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        s = (sum + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return neg ? 16'(64'd32768 - s) : 16'(64'd32768 + s);
    endfunction

endpackage

// ===== hw/rtl/palette_cycle_remap.sv =====
// Throughput: one word per cycle; busy is never raised. Depth is set by the two
// bit-per-stage dividers (range modulo 23, sine phase 16 stages) plus a three-stage
// reciprocal multiply for the time scale.
// Reset: synchronous active-low i_rst_n clears all valid bits; words in flight are dropped.
// Results cannot be held off by the receiver, so the pipeline never stalls.
module palette_cycle_remap #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pcr_pkg::t_in_word   i_word,
    output logic                o_strobe,
    output pcr_pkg::t_out_word  o_word
);
    import pcr_pkg::*;

    localparam int IDX_W = $clog2(SINE_TABLE_SIZE);

    assign busy = 1'b0;

    // ---------------- stage A: qualify and decode ----------------
    logic [8:0] n_size;
    logic       n_ok;
    t_side      n_a_side;

    assign n_size = {1'b0, i_word.range_high} - {1'b0, i_word.range_low} + 9'd1;
    // word dropped for zero rate, inverted range, range past palette, j outside range
    assign n_ok = start
               && (i_word.cycle_rate != 16'd0)
               && (i_word.range_high >= i_word.range_low)
               && ({1'b0, i_word.range_high} < 9'(PALETTE_ENTRIES))
               && ({1'b0, i_word.entry_pos} < n_size);

    always_comb begin
        n_a_side       = '0;
        n_a_side.lo    = i_word.range_low;
        n_a_side.j     = i_word.entry_pos;
        n_a_side.size  = n_size;
        n_a_side.rev   = (i_word.cycle_mode == MODE_REVERSE);
        n_a_side.pp    = (i_word.cycle_mode == MODE_PINGPONG);
        n_a_side.sine  = (i_word.cycle_mode == MODE_FULL_SINE)
                      || (i_word.cycle_mode == MODE_HALF_SINE);
        n_a_side.half  = (i_word.cycle_mode == MODE_HALF_SINE);
    end

    logic        r_a_vld;
    t_side       r_a_side;
    logic [15:0] r_a_rate;
    logic [31:0] r_a_ms;

    // ---------------- stage B: rate * ms ----------------
    logic        r_b_vld;
    t_side       r_b_side;
    logic [47:0] r_b_prod;

    // ---------------- stage C: saturation check, partial products of P * TIME_RECIP ----------------
    // P is below 2^42 whenever the time does not saturate
    logic        r_c_vld;
    t_side       r_c_side;
    logic [42:0] r_c_pp_ll;    // P[20:0]  * M[21:0]
    logic [41:0] r_c_pp_lh;    // P[20:0]  * M[42:22]
    logic [42:0] r_c_pp_hl;    // P[41:21] * M[21:0]
    logic [41:0] r_c_pp_hh;    // P[41:21] * M[42:22]
    t_side       n_c_side;

    always_comb begin
        n_c_side     = r_b_side;
        n_c_side.sat = (r_b_prod >= SAT_LIMIT);
    end

    // ---------------- stage M: pair up the partial products ----------------
    logic        r_m_vld;
    t_side       r_m_side;
    logic [64:0] r_m_lo;       // pp_ll + pp_lh << 22
    logic [64:0] r_m_hi;       // pp_hl + pp_hh << 22

    // ---------------- stage T: final sum, tm = sum >> 53 ----------------
    logic [85:0] n_t_sum;
    logic        r_t_vld;
    t_side       r_t_side;
    logic [30:0] r_t_quo;      // only meaningful when not saturated

    assign n_t_sum = 86'(r_m_lo) + {r_m_hi, 21'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_t_vld <= 1'b0;
        end else begin
            r_a_vld <= n_ok;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_m_vld <= r_c_vld;
            r_t_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_side  <= n_a_side;
        r_a_rate  <= i_word.cycle_rate;
        r_a_ms    <= i_word.time_ms;
        r_b_side  <= r_a_side;
        r_b_prod  <= 48'(r_a_rate) * 48'(r_a_ms);
        r_c_side  <= n_c_side;
        r_c_pp_ll <= 43'(r_b_prod[20:0]) * 43'(TIME_RECIP[21:0]);
        r_c_pp_lh <= 42'(r_b_prod[20:0]) * 42'(TIME_RECIP[42:22]);
        r_c_pp_hl <= 43'(r_b_prod[41:21]) * 43'(TIME_RECIP[21:0]);
        r_c_pp_hh <= 42'(r_b_prod[41:21]) * 42'(TIME_RECIP[42:22]);
        r_m_side  <= r_c_side;
        r_m_lo    <= 65'(r_c_pp_ll) + {1'b0, r_c_pp_lh, 22'd0};
        r_m_hi    <= 65'(r_c_pp_hl) + {1'b0, r_c_pp_hh, 22'd0};
        r_t_side  <= r_m_side;
        r_t_quo   <= n_t_sum[83:53];
    end

    // ---------------- divider 2: (tm >> 8) mod size (2*size for ping-pong) ----------------
    logic [30:0] n_tm;
    logic [9:0]  n_den2;
    t_side       n_d2_side;

    assign n_tm   = r_t_side.sat ? TM_MAX : r_t_quo;
    assign n_den2 = r_t_side.pp ? {r_t_side.size, 1'b0} : {1'b0, r_t_side.size};

    always_comb begin
        n_d2_side       = r_t_side;
        n_d2_side.tm_lo = n_tm[7:0];
    end

    logic        d2_vld;
    logic [9:0]  d2_rem;
    t_side       d2_side;

    pcr_divpipe #(.NUM_W(24), .DEN_W(10), .Q_W(23)) u_div_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_t_vld),
        .i_num   ({1'b0, n_tm[30:8]}),
        .i_den   (n_den2),
        .i_side  (n_d2_side),
        .o_valid (d2_vld),
        .o_quo   (),
        .o_rem   (d2_rem),
        .o_side  (d2_side)
    );

    // ---------------- stage E: offset step for linear and ping-pong ----------------
    logic [17:0] n_offs;
    logic [17:0] n_fold;
    logic [9:0]  n_kk;
    t_side       n_e_side;

    assign n_offs = {d2_rem, d2_side.tm_lo};
    // fold back past the range end
    assign n_fold = (n_offs > {1'b0, d2_side.size, 8'h00})
                  ? ({d2_side.size, 9'h000} - n_offs) : n_offs;
    assign n_kk   = n_fold[17:8];

    always_comb begin
        n_e_side = d2_side;
        if (d2_side.pp) begin
            n_e_side.k = (n_kk == {1'b0, d2_side.size}) ? 8'd0 : n_kk[7:0];
        end else begin
            n_e_side.k = d2_rem[7:0];
        end
    end

    logic        r_e_vld;
    t_side       r_e_side;
    logic [15:0] r_e_x;      // tm mod (size*256)

    // ---------------- divider 3: phase = x*256 / size ----------------
    logic        d3_vld;
    logic [15:0] d3_quo;
    t_side       d3_side;

    pcr_divpipe #(.NUM_W(24), .DEN_W(9), .Q_W(16)) u_div_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_vld),
        .i_num   ({r_e_x, 8'h00}),
        .i_den   (r_e_side.size),
        .i_side  (r_e_side),
        .o_valid (d3_vld),
        .o_quo   (d3_quo),
        .o_rem   (),
        .o_side  (d3_side)
    );

    // ---------------- stage F: table index, G: table read, H: scale by size ----------------
    logic [28:0]      n_idx_prod;
    logic             r_f_vld;
    t_side            r_f_side;
    logic [IDX_W-1:0] r_f_idx;
    logic             r_g_vld;
    t_side            r_g_side;
    logic [15:0]      rom_val;
    logic             r_h_vld;
    t_side            r_h_side;
    logic [24:0]      r_h_prod;

    assign n_idx_prod = 29'(d3_quo) * 29'(SINE_TABLE_SIZE);

    pcr_sine_rom #(.SINE_TABLE_SIZE(SINE_TABLE_SIZE)) u_sine (
        .i_clk (i_clk),
        .i_idx (r_f_idx),
        .o_val (rom_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else begin
            r_e_vld <= d2_vld;
            r_f_vld <= d3_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_side <= n_e_side;
        r_e_x    <= {d2_rem[7:0], d2_side.tm_lo};
        r_f_side <= d3_side;
        r_f_idx  <= n_idx_prod[16 +: IDX_W];
        r_g_side <= r_f_side;
        r_h_side <= r_g_side;
        r_h_prod <= 25'(rom_val) * 25'(r_g_side.size);
    end

    // ---------------- output stage: rotate ----------------
    logic [7:0] n_k;
    logic [8:0] n_sum;
    logic [8:0] n_pos;

    assign n_k = !r_h_side.sine ? r_h_side.k
               : (r_h_side.half ? 8'(r_h_prod >> 17) : r_h_prod[23:16]);
    assign n_sum = {1'b0, r_h_side.j} + {1'b0, n_k};

    always_comb begin
        if (r_h_side.rev) begin
            n_pos = (n_sum >= r_h_side.size) ? (n_sum - r_h_side.size) : n_sum;
        end else if (r_h_side.j >= n_k) begin
            n_pos = {1'b0, r_h_side.j} - {1'b0, n_k};
        end else begin
            n_pos = {1'b0, r_h_side.j} + r_h_side.size - {1'b0, n_k};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_word.dest_index     <= r_h_side.lo + r_h_side.j;
        o_word.source_index   <= r_h_side.lo + n_pos[7:0];
        o_word.time_saturated <= r_h_side.sat;
    end

endmodule

// ===== hw/rtl/pcr_divpipe.sv =====
// Restoring divider, one quotient bit per register stage.
// Requires num >> Q_W < den for a meaningful result.
module pcr_divpipe #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 10,
    parameter int Q_W   = 23
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    input  pcr_pkg::t_side     i_side,
    output logic               o_valid,
    output logic [Q_W-1:0]     o_quo,
    output logic [DEN_W-1:0]   o_rem,
    output pcr_pkg::t_side     o_side
);
    import pcr_pkg::*;

    logic             r_vld  [Q_W];
    logic [DEN_W-1:0] r_rem  [Q_W];
    logic [Q_W-1:0]   r_w    [Q_W];   // numerator bits shift out, quotient bits in
    logic [DEN_W-1:0] r_den  [Q_W];
    t_side            r_side [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic             s_vld;
        logic [DEN_W-1:0] s_rem;
        logic [DEN_W-1:0] s_den;
        logic [Q_W-1:0]   s_w;
        t_side            s_side;
        logic [DEN_W:0]   s_t;

        if (s == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_rem  = DEN_W'(i_num[NUM_W-1:Q_W]);
            assign s_w    = i_num[Q_W-1:0];
            assign s_den  = i_den;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[s-1];
            assign s_rem  = r_rem[s-1];
            assign s_w    = r_w[s-1];
            assign s_den  = r_den[s-1];
            assign s_side = r_side[s-1];
        end

        assign s_t = {s_rem, s_w[Q_W-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[s]  <= s_den;
            r_side[s] <= s_side;
            if (s_t >= {1'b0, s_den}) begin
                r_rem[s] <= DEN_W'(s_t - {1'b0, s_den});
                r_w[s]   <= {s_w[Q_W-2:0], 1'b1};
            end else begin
                r_rem[s] <= s_t[DEN_W-1:0];
                r_w[s]   <= {s_w[Q_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_w[Q_W-1];
    assign o_rem   = r_rem[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

// ===== hw/rtl/pcr_sine_rom.sv =====
// Sine table holding sin+1 in Q1.15, registered read.
module pcr_sine_rom #(
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  logic                               i_clk,
    input  logic [$clog2(SINE_TABLE_SIZE)-1:0] i_idx,
    output logic [15:0]                        o_val
);
    import pcr_pkg::*;

    logic [15:0] c_rom [SINE_TABLE_SIZE];

    for (genvar gi = 0; gi < SINE_TABLE_SIZE; gi++) begin : g_rom
        localparam int unsigned QV   = 4 * gi;
        localparam int unsigned QUAD = QV / SINE_TABLE_SIZE;
        localparam int unsigned REMV = QV % SINE_TABLE_SIZE;
        localparam int unsigned MV   = (QUAD % 2 == 1) ? SINE_TABLE_SIZE - REMV : REMV;
        localparam logic [63:0] ANG  = (HALF_PI_Q30 * 64'(MV)) / 64'(SINE_TABLE_SIZE);
        localparam logic [15:0] VAL  = sine_val(ANG, ((QUAD / 2) % 2) == 1);
        assign c_rom[gi] = VAL;
    end

    always_ff @(posedge i_clk) begin
        o_val <= c_rom[i_idx];
    end

endmodule
